FILE: rtl/underflow_window_self_heal_monitor_core_macros.svh
// ---------------------------------------------------------------------------
// Underflow window self-heal monitor: assertion macros
// Shared assertion forms for the checker, clocked on clk, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef UNDERFLOW_WINDOW_SELF_HEAL_MONITOR_CORE_MACROS_SVH
`define UNDERFLOW_WINDOW_SELF_HEAL_MONITOR_CORE_MACROS_SVH

// concurrent assertion on clk, disabled while arst_n is low
`define UWSHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form: when cond holds, expr must hold in the same cycle
`define UWSHM_ASSERT_IMPL(lbl, cond, expr, msg) \
	`UWSHM_ASSERT(lbl, (cond) |-> (expr), msg)

`endif

FILE: rtl/uwshm_pkg.sv
// ---------------------------------------------------------------------------
// Underflow window self-heal monitor: package
// Constants and codes shared by the core and its checker.
// ---------------------------------------------------------------------------
package uwshm_pkg;

	localparam int unsigned STAMP_W = 32;
	localparam int unsigned COUNT_W = 8;

	// one day in seconds
	localparam logic [STAMP_W-1:0] WINDOW_RESET = STAMP_W'(60 * 60 * 24);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// persistent flag write codes
	typedef enum logic [1:0] {
		FLAG_NONE = 2'd0,
		FLAG_ON   = 2'd1,
		FLAG_OFF  = 2'd2
	} flag_write_t;

endpackage

FILE: rtl/underflow_window_self_heal_monitor_core.sv
// ---------------------------------------------------------------------------
// Underflow window self-heal monitor core
// Counts display underflows in a sliding window, on a third hit asks for a
// healing notification; persistent flag on if it is sent, off once voted.
// ---------------------------------------------------------------------------
// channel   handshake              payload
// in        in_valid / in_ready    func, now_seconds, clear_succeeded,
//                                  no_layers, stored_flag_on, send_ok
// out       out_valid / out_ready  notify_attempt, flag_write, window_hit,
//                                  is_voted, is_stopped, event_count
// cfg       cfg_we                 cfg_wdata (window length in seconds)
//
// one transaction per cycle sustained unless out_ready stalls the result;
// an accepted input passes the input register, then the result register.
// the state update and window compares sit between those two registers.
// async reset clears state, the window register (to one day) and valids.
// a stalled result holds; the input register still refills while the
// result register drains in the same cycle.
// ---------------------------------------------------------------------------
module underflow_window_self_heal_monitor_core
	import uwshm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [STAMP_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [STAMP_W-1:0] now_seconds,
	input  logic               clear_succeeded,
	input  logic               no_layers,
	input  logic               stored_flag_on,
	input  logic               send_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               notify_attempt,
	output logic [1:0]         flag_write,
	output logic               window_hit,
	output logic               is_voted,
	output logic               is_stopped,
	output logic [COUNT_W-1:0] event_count
);

	// input register
	logic               valid_s1;
	logic               func_s1;
	logic [STAMP_W-1:0] now_s1;
	logic               cleared_s1;
	logic               no_layers_s1;
	logic               flag_on_s1;
	logic               send_ok_s1;

	// monitor state
	logic [STAMP_W-1:0] window_q;
	logic [STAMP_W-1:0] oldest_q;
	logic [STAMP_W-1:0] middle_q;
	logic [COUNT_W-1:0] count_q;
	logic               voted_q;
	logic               stopped_q;

	// result register
	logic               out_valid_q;
	logic               attempt_q;
	flag_write_t        fwrite_q;
	logic               hit_q;

	logic               take_s1;
	logic               in_acc;

	logic [STAMP_W-1:0] oldest_n;
	logic [STAMP_W-1:0] middle_n;
	logic [COUNT_W-1:0] count_n;
	logic               voted_n;
	logic               stopped_n;
	logic               attempt_n;
	flag_write_t        fwrite_n;
	logic               hit_n;
	logic [STAMP_W:0]   diff_old;
	logic [STAMP_W:0]   diff_mid;
	logic               out_old;
	logic               out_mid;

	assign take_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || take_s1;
	assign in_acc   = in_valid && in_ready;

	// signed distance; a stamp later than now is always inside the window
	assign diff_old = {1'b0, now_s1} - {1'b0, oldest_q};
	assign diff_mid = {1'b0, now_s1} - {1'b0, middle_q};
	assign out_old  = !diff_old[STAMP_W] && (diff_old[STAMP_W-1:0] >= window_q);
	assign out_mid  = !diff_mid[STAMP_W] && (diff_mid[STAMP_W-1:0] >= window_q);

	always_comb begin
		oldest_n  = oldest_q;
		middle_n  = middle_q;
		count_n   = count_q;
		voted_n   = voted_q;
		stopped_n = stopped_q;
		attempt_n = 1'b0;
		fwrite_n  = FLAG_NONE;
		hit_n     = 1'b0;
		if (func_s1) begin
			if (flag_on_s1) begin
				attempt_n = 1'b1;
				if (send_ok_s1) begin
					voted_n = 1'b1;
				end
			end
		end else if (!cleared_s1 && !no_layers_s1 && !stopped_q) begin
			if (count_q != COUNT_MAX) begin
				count_n = count_q + COUNT_W'(1);
			end
			// zero stamps mean empty slots
			if (oldest_q == '0) begin
				oldest_n = now_s1;
			end else if (middle_q == '0) begin
				if (out_old) begin
					oldest_n = now_s1;
					count_n  = COUNT_W'(1);
				end else begin
					middle_n = now_s1;
				end
			end else if (out_old) begin
				if (out_mid) begin
					oldest_n = now_s1;
					middle_n = '0;
					count_n  = COUNT_W'(1);
				end else begin
					oldest_n = middle_q;
					middle_n = now_s1;
					count_n  = COUNT_W'(2);
				end
			end else begin
				hit_n = 1'b1;
			end
			if (hit_n) begin
				if (voted_q) begin
					fwrite_n  = FLAG_OFF;
					stopped_n = 1'b1;
				end else begin
					attempt_n = 1'b1;
					if (send_ok_s1) begin
						count_n  = '0;
						oldest_n = '0;
						middle_n = '0;
						voted_n  = 1'b1;
						fwrite_n = FLAG_ON;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1      <= func;
			now_s1       <= now_seconds;
			cleared_s1   <= clear_succeeded;
			no_layers_s1 <= no_layers;
			flag_on_s1   <= stored_flag_on;
			send_ok_s1   <= send_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			middle_q    <= '0;
			count_q     <= '0;
			voted_q     <= 1'b0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			oldest_q    <= oldest_n;
			middle_q    <= middle_n;
			count_q     <= count_n;
			voted_q     <= voted_n;
			stopped_q   <= stopped_n;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			attempt_q <= attempt_n;
			fwrite_q  <= fwrite_n;
			hit_q     <= hit_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign notify_attempt = attempt_q;
	assign flag_write     = fwrite_q;
	assign window_hit     = hit_q;
	assign is_voted       = voted_q;
	assign is_stopped     = stopped_q;
	assign event_count    = count_q;

endmodule

FILE: rtl/uwshm_checker.sv
// ---------------------------------------------------------------------------
// Underflow window self-heal monitor: checker
// Port-level checks on result consistency, bound to the core.
// ---------------------------------------------------------------------------
`include "underflow_window_self_heal_monitor_core_macros.svh"

module uwshm_checker
	import uwshm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               notify_attempt,
	input logic [1:0]         flag_write,
	input logic               window_hit,
	input logic               is_voted,
	input logic               is_stopped,
	input logic [COUNT_W-1:0] event_count
);

	// a held result keeps its payload
	`UWSHM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(flag_write) && $stable(event_count) && $stable(is_voted), "result changed while stalled")

	// stopping only ever follows a vote
	`UWSHM_ASSERT_IMPL(a_stop_voted, out_valid && is_stopped, is_voted, "stopped without vote")

	// flag on: hit with a successful notification clears the history
	`UWSHM_ASSERT_IMPL(a_flag_on, out_valid && flag_write == FLAG_ON, window_hit && notify_attempt && is_voted && event_count == '0, "flag on without healing vote")

	// flag off: hit after the vote, no notification, monitor stopped
	`UWSHM_ASSERT_IMPL(a_flag_off, out_valid && flag_write == FLAG_OFF, window_hit && !notify_attempt && is_stopped, "flag off without stop")

endmodule

bind underflow_window_self_heal_monitor_core uwshm_checker u_uwshm_checker (.*);

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// Underflow window self-heal monitor: testbench
// Drives underflow and boot-check transactions with random gaps and
// back-pressure and predicts every result with a local model of the
// window, vote and stop logic. Runs through several window lengths and
// checks each result field by field.
// ---------------------------------------------------------------------------
module testbench;
	import uwshm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic               func;
		logic [STAMP_W-1:0] now;
		logic               cleared;
		logic               no_layers;
		logic               flag_on;
		logic               send_ok;
	} heal_item_t;

	typedef struct packed {
		logic               attempt;
		flag_write_t        fwrite;
		logic               hit;
		logic               voted;
		logic               stopped;
		logic [COUNT_W-1:0] count;
	} heal_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [STAMP_W-1:0] cfg_wdata;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = 1'b0;
	logic [STAMP_W-1:0] now_seconds = '0;
	logic               clear_succeeded = 1'b0;
	logic               no_layers = 1'b0;
	logic               stored_flag_on = 1'b0;
	logic               send_ok = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               notify_attempt;
	logic [1:0]         flag_write;
	logic               window_hit;
	logic               is_voted;
	logic               is_stopped;
	logic [COUNT_W-1:0] event_count;

	heal_item_t   pending_events_q[$];
	heal_result_t expected_outcomes_q[$];

	// local copy of the monitor state
	logic [STAMP_W-1:0] m_window = WINDOW_RESET;
	logic [STAMP_W-1:0] m_oldest = '0;
	logic [STAMP_W-1:0] m_middle = '0;
	logic [COUNT_W-1:0] m_count = '0;
	logic               m_voted = 1'b0;
	logic               m_stopped = 1'b0;

	logic               in_fire = 1'b0;
	logic               out_fire = 1'b0;
	int unsigned        err_count = 0;
	int unsigned        results_seen = 0;
	int unsigned        cycle_count = 0;
	logic [STAMP_W-1:0] gen_now = '0;

	underflow_window_self_heal_monitor_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.now_seconds    (now_seconds),
		.clear_succeeded(clear_succeeded),
		.no_layers      (no_layers),
		.stored_flag_on (stored_flag_on),
		.send_ok        (send_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.notify_attempt (notify_attempt),
		.flag_write     (flag_write),
		.window_hit     (window_hit),
		.is_voted       (is_voted),
		.is_stopped     (is_stopped),
		.event_count    (event_count)
	);

	always #10 clk = ~clk;

	// signed distance, so a stamp in the future is always inside
	function automatic logic beyond_window(logic [STAMP_W-1:0] t, logic [STAMP_W-1:0] stamp);
		longint diff;
		diff = longint'({32'd0, t}) - longint'({32'd0, stamp});
		return diff >= longint'({32'd0, m_window});
	endfunction

	// shuffles the kept stamps, returns 1 on a third underflow in the window
	function automatic logic window_advance(logic [STAMP_W-1:0] t);
		if (m_oldest == '0) begin
			m_oldest = t;
			return 1'b0;
		end
		if (m_middle == '0) begin
			if (beyond_window(t, m_oldest)) begin
				m_oldest = t;
				m_count = COUNT_W'(1);
			end else begin
				m_middle = t;
			end
			return 1'b0;
		end
		if (beyond_window(t, m_oldest)) begin
			if (beyond_window(t, m_middle)) begin
				m_oldest = t;
				m_middle = '0;
				m_count = COUNT_W'(1);
			end else begin
				m_oldest = m_middle;
				m_middle = t;
				m_count = COUNT_W'(2);
			end
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic heal_result_t heal_predict(heal_item_t it);
		heal_result_t r;
		r = '0;
		r.fwrite = FLAG_NONE;
		if (it.func) begin
			if (it.flag_on) begin
				r.attempt = 1'b1;
				if (it.send_ok)
					m_voted = 1'b1;
			end
		end else if (!it.cleared && !it.no_layers && !m_stopped) begin
			if (m_count != COUNT_MAX)
				m_count = m_count + 1'b1;
			if (window_advance(it.now)) begin
				r.hit = 1'b1;
				if (m_voted) begin
					r.fwrite = FLAG_OFF;
					m_stopped = 1'b1;
				end else begin
					r.attempt = 1'b1;
					if (it.send_ok) begin
						m_count = '0;
						m_oldest = '0;
						m_middle = '0;
						m_voted = 1'b1;
						r.fwrite = FLAG_ON;
					end
				end
			end
		end
		r.voted = m_voted;
		r.stopped = m_stopped;
		r.count = m_count;
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	task automatic queue_item(logic f, logic [STAMP_W-1:0] t, logic clr, logic nol,
			logic flg, logic sok);
		heal_item_t it;
		it = '{func: f, now: t, cleared: clr, no_layers: nol, flag_on: flg, send_ok: sok};
		pending_events_q.push_back(it);
	endtask

	// random traffic that never sends successfully, so the vote stays clear
	task automatic fill_random(int unsigned n_active);
		int unsigned done_n;
		int unsigned sel;
		logic [STAMP_W-1:0] cap;
		logic [1:0] ign;
		heal_item_t it;
		done_n = 0;
		cap = (m_window > 32'h4000_0000) ? 32'h4000_0000 : m_window;
		while (done_n < n_active) begin
			sel = $urandom_range(0, 99);
			it = '0;
			it.flag_on = 1'($urandom_range(0, 1));
			if (sel < 65) begin
				if ($urandom_range(0, 5) == 0)
					gen_now = gen_now + $urandom_range(0, 2 * cap);
				else
					gen_now = gen_now + $urandom_range(0, cap / 3 + 1);
				it.now = gen_now;
				done_n++;
			end else if (sel < 75) begin
				ign = 2'($urandom_range(1, 3));
				it.cleared = ign[0];
				it.no_layers = ign[1];
				it.now = $urandom;
				it.send_ok = 1'($urandom_range(0, 1));
			end else if (sel < 88) begin
				it.func = 1'b1;
				it.cleared = 1'($urandom_range(0, 1));
				it.no_layers = 1'($urandom_range(0, 1));
				it.now = $urandom;
				it.send_ok = it.flag_on ? 1'b0 : 1'(($urandom_range(0, 1)));
				done_n++;
			end else if (sel < 94) begin
				it.now = $urandom;
				done_n++;
			end else begin
				// time going back a little
				it.now = gen_now - $urandom_range(0, 50);
				done_n++;
			end
			pending_events_q.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (pending_events_q.size() != 0 || in_valid || expected_outcomes_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(logic [STAMP_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		m_window = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin : input_capture
		heal_item_t acc;
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			acc = '{func: func, now: now_seconds, cleared: clear_succeeded,
				no_layers: no_layers, flag_on: stored_flag_on, send_ok: send_ok};
			expected_outcomes_q.push_back(heal_predict(acc));
		end
	end

	always @(posedge clk) begin : result_check
		heal_result_t exp_r;
		out_fire = arst_n && out_valid && out_ready;
		if (out_fire) begin
			results_seen++;
			if (expected_outcomes_q.size() == 0) begin
				$display("%0t: unexpected result attempt %0d flag %0d hit %0d voted %0d stopped %0d count %0d",
					$time, notify_attempt, flag_write, window_hit, is_voted, is_stopped,
					event_count);
				err_count++;
			end else begin
				exp_r = expected_outcomes_q.pop_front();
				check_field("notify_attempt", 64'(exp_r.attempt), 64'(notify_attempt));
				check_field("flag_write", 64'(exp_r.fwrite), 64'(flag_write));
				check_field("window_hit", 64'(exp_r.hit), 64'(window_hit));
				check_field("is_voted", 64'(exp_r.voted), 64'(is_voted));
				check_field("is_stopped", 64'(exp_r.stopped), 64'(is_stopped));
				check_field("event_count", 64'(exp_r.count), 64'(event_count));
			end
		end
	end

	always @(negedge clk) begin : sender
		heal_item_t nxt;
		int unsigned snd_gap;
		logic snd_quiet;
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (snd_gap > 0) begin
					snd_gap--;
					in_valid <= 1'b0;
				end else if (pending_events_q.size() > 0) begin
					nxt = pending_events_q.pop_front();
					func <= nxt.func;
					now_seconds <= nxt.now;
					clear_succeeded <= nxt.cleared;
					no_layers <= nxt.no_layers;
					stored_flag_on <= nxt.flag_on;
					send_ok <= nxt.send_ok;
					in_valid <= 1'b1;
					if ($urandom_range(0, 31) == 0)
						snd_quiet = !snd_quiet;
					snd_gap = snd_quiet ? 0 : $urandom_range(0, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end else begin
			snd_gap = 0;
			snd_quiet = 1'b0;
		end
	end

	always @(negedge clk) begin : receiver
		int unsigned rcv_stall;
		int unsigned rcv_hold;
		logic rcv_quiet;
		if (arst_n) begin
			if (out_fire) begin
				if ($urandom_range(0, 31) == 0)
					rcv_quiet = !rcv_quiet;
				rcv_stall = rcv_quiet ? 0 : $urandom_range(0, 15);
				// long hold-off so the core backs up and drops in_ready
				if (results_seen == 600 || results_seen == 1300)
					rcv_hold = 250;
			end
			if (rcv_hold > 0) begin
				rcv_hold--;
				out_ready <= 1'b0;
			end else if (rcv_stall > 0) begin
				rcv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end else begin
			rcv_stall = 0;
			rcv_hold = 0;
			rcv_quiet = 1'b0;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// boot checks, ignored events, zero stamp, going back, reshuffles
		queue_item(1'b1, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		queue_item(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
		queue_item(1'b0, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd100, 1'b0, 1'b1, 1'b0, 1'b0);
		queue_item(1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd10, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd20, 1'b0, 1'b0, 1'b1, 1'b0);
		queue_item(1'b0, 32'd3, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd86405, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);

		set_window(32'd1);
		queue_item(1'b0, 32'd500, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd500, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'd501, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'h1000, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_item(1'b0, 32'h1000, 1'b0, 1'b0, 1'b0, 1'b0);
		gen_now = 32'h1000;
		fill_random(175);

		set_window(32'd7);
		fill_random(220);
		set_window(32'd1000);
		fill_random(220);
		// widest window never expires, so the count saturates
		set_window(32'hFFFF_FFFF);
		fill_random(260);
		set_window(32'd86400);
		fill_random(220);
		set_window($urandom_range(32'hFFFF_FFFF, 1));
		fill_random(175);
		set_window(32'h8000_0000);
		fill_random(175);

		// successful send votes, the next hit writes the flag off and stops
		set_window(32'hFFFF_FFFF);
		gen_now = gen_now + 1;
		repeat (7) queue_item(1'b0, gen_now, 1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
		queue_item(1'b1, gen_now, 1'b0, 1'b0, 1'b1, 1'b1);
		queue_item(1'b0, gen_now, 1'b1, 1'b0, 1'b0, 1'b1);
		repeat (30)
			queue_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));

		wait_drained();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
